/* rtl/core/rid_pkg.sv */
// Shared types and constants for the resistor id classifier.
`default_nettype none
package rid_pkg;

  localparam int CHANNELS    = 4;
  localparam int SAMPLE_BITS = 10;
  localparam int WINDOWS     = 4;
  localparam int BOUND_BITS  = 2 * SAMPLE_BITS;
  localparam int TIME_BITS   = 32;
  localparam int DELAY_BITS  = 16;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = BOUND_BITS;

  // Class codes; a window's index equals its class code.
  typedef enum logic [2:0] {
    CLS_C         = 3'd0,
    CLS_B         = 3'd1,
    CLS_A         = 3'd2,
    CLS_ONE       = 3'd3,
    CLS_UNPLUGGED = 3'd4,
    CLS_ERROR     = 3'd5
  } class_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_WIN_C     = 3'd0,
    CFG_WIN_B     = 3'd1,
    CFG_WIN_A     = 3'd2,
    CFG_WIN_ONE   = 3'd3,
    CFG_UNPLUGGED = 3'd4,
    CFG_DEBOUNCE  = 3'd5
  } cfg_idx_t;

  localparam logic [SAMPLE_BITS-1:0] UNPLUGGED_RESET = {SAMPLE_BITS{1'b1}};
  localparam logic [DELAY_BITS-1:0]  DEBOUNCE_RESET  = 16'd50;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [WINDOWS-1:0][BOUND_BITS-1:0] bounds_t;

  // One result beat: accepted classes and their change mask.
  typedef struct packed {
    class_t [CHANNELS-1:0] stable;
    logic   [CHANNELS-1:0] changed;
  } result_t;

endpackage
`default_nettype wire

/* rtl/core/rid_classify.sv */
// Window classifier for one channel's sample.
`default_nettype none
module rid_classify (
  input  wire rid_pkg::sample_t                   sample,
  input  wire rid_pkg::bounds_t                   bounds,
  input  wire logic [rid_pkg::SAMPLE_BITS-1:0]    unplugged_thr,
  output rid_pkg::class_t                         cls
);

  logic [rid_pkg::WINDOWS-1:0] hit;

  // Test every open window in parallel.
  always_comb begin
    for (int w = 0; w < rid_pkg::WINDOWS; w++) begin
      hit[w] = (sample > bounds[w][rid_pkg::SAMPLE_BITS-1:0]) &&
               (sample < bounds[w][rid_pkg::BOUND_BITS-1:rid_pkg::SAMPLE_BITS]);
    end
  end

  // Pick the first window that fits, else fall back on the threshold.
  always_comb begin
    if (sample > unplugged_thr) begin
      cls = rid_pkg::CLS_UNPLUGGED;
    end else begin
      cls = rid_pkg::CLS_ERROR;
    end
    for (int w = rid_pkg::WINDOWS - 1; w >= 0; w--) begin
      if (hit[w]) begin
        cls = rid_pkg::class_t'(3'(w));
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/rid_debounce.sv */
// Change tracking and debounce state for all channels.
`default_nettype none
module rid_debounce (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   step,
  input  wire rid_pkg::class_t [rid_pkg::CHANNELS-1:0] raw,
  input  wire logic [rid_pkg::TIME_BITS-1:0]    now_ms,
  input  wire logic [rid_pkg::DELAY_BITS-1:0]   delay_ms,
  output rid_pkg::result_t                      res
);

  rid_pkg::class_t [rid_pkg::CHANNELS-1:0] raw_prev_r;
  rid_pkg::class_t [rid_pkg::CHANNELS-1:0] stable_r;
  logic [rid_pkg::TIME_BITS-1:0]           change_time_r;
  logic [rid_pkg::TIME_BITS-1:0]           change_time_nxt;
  logic [rid_pkg::TIME_BITS-1:0]           elapsed;
  logic                                    moved;
  logic                                    settled;

  // Detect any raw class movement since the previous beat.
  always_comb begin
    moved = 1'b0;
    for (int i = 0; i < rid_pkg::CHANNELS; i++) begin
      if (raw[i] != raw_prev_r[i]) begin
        moved = 1'b1;
      end
    end
  end

  // Restamp on movement; a restamp means zero elapsed time.
  assign change_time_nxt = moved ? now_ms : change_time_r;
  assign elapsed         = now_ms - change_time_r;
  assign settled         = !moved &&
                           (elapsed > {{(rid_pkg::TIME_BITS-rid_pkg::DELAY_BITS){1'b0}},
                                       delay_ms});

  // Take raw classes into the stable set once settled.
  always_comb begin
    for (int i = 0; i < rid_pkg::CHANNELS; i++) begin
      res.changed[i] = settled && (stable_r[i] != raw[i]);
      res.stable[i]  = settled ? raw[i] : stable_r[i];
    end
  end

  // Advance state on each beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rid_pkg::CHANNELS; i++) begin
        raw_prev_r[i] <= rid_pkg::CLS_ERROR;
        stable_r[i]   <= rid_pkg::CLS_ERROR;
      end
      change_time_r <= '0;
    end else if (step) begin
      raw_prev_r    <= raw;
      stable_r      <= res.stable;
      change_time_r <= change_time_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/resistor_id_classifier_debounce.sv */
// Path: an accepted beat is held in the input register, then moves into the result register that drives the output.
// Throughput: one beat per cycle while the output is not stalled; the input and result registers advance together,
// with classification and the 32-bit elapsed-time compare in between.
// Reset: synchronous, active low; windows clear to empty, threshold 1023, delay 50 ms,
// stable and previous raw classes to error, change time to zero.
`default_nettype none
module resistor_id_classifier_debounce (
  input  wire                                      clk,
  input  wire                                      rst_n,
  input  wire                                      in_valid,
  output logic                                     in_stall,
  input  wire logic [rid_pkg::SAMPLE_BITS-1:0]     in_sample_0,
  input  wire logic [rid_pkg::SAMPLE_BITS-1:0]     in_sample_1,
  input  wire logic [rid_pkg::SAMPLE_BITS-1:0]     in_sample_2,
  input  wire logic [rid_pkg::SAMPLE_BITS-1:0]     in_sample_3,
  input  wire logic [rid_pkg::TIME_BITS-1:0]       in_now_ms,
  output logic                                     out_valid,
  input  wire                                      out_stall,
  output logic [2:0]                               out_stable_0,
  output logic [2:0]                               out_stable_1,
  output logic [2:0]                               out_stable_2,
  output logic [2:0]                               out_stable_3,
  output logic [rid_pkg::CHANNELS-1:0]             out_changed_mask,
  input  wire                                      cfg_we,
  input  wire logic [rid_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire logic [rid_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

  rid_pkg::bounds_t                          bounds_r;
  logic [rid_pkg::SAMPLE_BITS-1:0]           unplugged_r;
  logic [rid_pkg::DELAY_BITS-1:0]            delay_r;

  logic                                      in_valid_r;
  rid_pkg::sample_t [rid_pkg::CHANNELS-1:0]  sample_r;
  logic [rid_pkg::TIME_BITS-1:0]             now_r;
  logic                                      out_valid_r;
  rid_pkg::result_t                          res_r;
  rid_pkg::result_t                          res_nxt;
  rid_pkg::class_t [rid_pkg::CHANNELS-1:0]   raw;
  logic                                      out_free;
  logic                                      step;
  logic                                      in_take;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bounds_r    <= '0;
      unplugged_r <= rid_pkg::UNPLUGGED_RESET;
      delay_r     <= rid_pkg::DEBOUNCE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rid_pkg::CFG_WIN_C:     bounds_r[0] <= cfg_wdata;
        rid_pkg::CFG_WIN_B:     bounds_r[1] <= cfg_wdata;
        rid_pkg::CFG_WIN_A:     bounds_r[2] <= cfg_wdata;
        rid_pkg::CFG_WIN_ONE:   bounds_r[3] <= cfg_wdata;
        rid_pkg::CFG_UNPLUGGED: unplugged_r <= cfg_wdata[rid_pkg::SAMPLE_BITS-1:0];
        rid_pkg::CFG_DEBOUNCE:  delay_r     <= cfg_wdata[rid_pkg::DELAY_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the input register drains whenever the result register is free.
  assign out_free = !out_valid_r || !out_stall;
  assign step     = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  // Hold the input beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (out_free || !in_valid_r) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      sample_r[0] <= in_sample_0;
      sample_r[1] <= in_sample_1;
      sample_r[2] <= in_sample_2;
      sample_r[3] <= in_sample_3;
      now_r       <= in_now_ms;
    end
  end

  // Classify each channel.
  for (genvar g = 0; g < rid_pkg::CHANNELS; g++) begin : g_chan
    rid_classify u_classify (
      .sample        (sample_r[g]),
      .bounds        (bounds_r),
      .unplugged_thr (unplugged_r),
      .cls           (raw[g])
    );
  end

  rid_debounce u_debounce (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .raw      (raw),
    .now_ms   (now_r),
    .delay_ms (delay_r),
    .res      (res_nxt)
  );

  // Hold the result beat until taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_stable_0     = res_r.stable[0];
  assign out_stable_1     = res_r.stable[1];
  assign out_stable_2     = res_r.stable[2];
  assign out_stable_3     = res_r.stable[3];
  assign out_changed_mask = res_r.changed;

endmodule
`default_nettype wire
